// ===== design/rmh_pkg.sv =====
package rmh_pkg;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned HEAP_DEPTH = 4096;
  localparam int unsigned ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(8191);
  localparam logic [CNT_W-1:0] HEAP_FULL = CNT_W'(HEAP_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_PUSH_RD,
    S_PUSH_CMP,
    S_POST,
    S_POP_TOP,
    S_POP_LAST,
    S_POP_LOAD,
    S_POP_C1,
    S_POP_C2,
    S_POP_C3,
    S_POP_CMP,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_INS,
    PH_POP,
    PH_MOV
  } phase_e;

endpackage

// ===== design/rmh_heap_ram.sv =====
module rmh_heap_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/running_median_two_heaps_core.sv =====
// running median of a signed sample stream, kept in a max-heap (lower half)
// and a min-heap (upper half) with the median held apart.
// input transfer: s_axis_tdata = sample, s_axis_tuser = first of sequence.
// output transfer: m_axis_tdata = median, position; m_axis_tuser = overflowed.
// a first sample skips the heaps and goes straight to the result.
// other samples: a push, then on odd positions, when the pushed heap holds more
// than the other, a pop and a second push, all through one compare unit and one
// port pair per heap memory; the heaps hold 4096 entries each.
// even positions and dropped samples give no result.
// one item is in work at a time; s_axis_tready is high only when idle.
// the result sits in an output register, so a new item is taken while it waits;
// a stalled receiver holds the block before its next result.
// reset clears counts, median and the overflow flag; heap memories need no
// clearing since the counts bound every read.
module running_median_two_heaps_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rmh_pkg::SAMPLE_W-1:0]   s_axis_tdata,   // sample
  input  logic                           s_axis_tuser,   // first_of_sequence
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rmh_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // median, position, pad
  output logic                           m_axis_tuser    // overflowed
);

  localparam int unsigned W  = rmh_pkg::SAMPLE_W;
  localparam int unsigned AW = rmh_pkg::ADDR_W;
  localparam int unsigned CW = rmh_pkg::CNT_W;

  rmh_pkg::state_e state_q, state_d;
  rmh_pkg::phase_e ph_q, ph_d;

  logic          sel_q, sel_d, up_q, up_d;
  logic [W-1:0]  v_q, v_d, pv_q, pv_d, med_q, med_d;
  logic [W-1:0]  top_q, top_d, last_q, last_d, best_q, best_d;
  logic [AW-1:0] idx_q, idx_d, bc_q, bc_d;
  logic [CW-1:0] n_q, n_d, lcnt_q, lcnt_d, ucnt_q, ucnt_d, scnt_q, scnt_d;
  logic          ovf_q, ovf_d;
  logic          ov_q, ov_d;
  logic [W-1:0]  om_q, om_d;
  logic [CW-1:0] op_q, op_d;
  logic          oo_q, oo_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [W-1:0]  mem_wdata, lo_rdata, up_rdata, rdata;

  logic signed [W-1:0] cmp_a, cmp_b;
  logic          cmp_max, above;

  logic          first_hit, full_hit, dec_up, slot_free;
  logic [CW-1:0] tgt_cnt, sel_cnt, c_full, bc_next;
  logic [AW-1:0] parent;

  assign rdata     = sel_q ? up_rdata : lo_rdata;
  assign above     = cmp_max ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
  assign first_hit = s_axis_tuser || (scnt_q == '0);
  assign dec_up    = above;
  assign tgt_cnt   = dec_up ? ucnt_q : lcnt_q;
  assign full_hit  = (scnt_q >= rmh_pkg::COUNT_MAX) || (tgt_cnt >= rmh_pkg::HEAP_FULL);
  assign sel_cnt   = sel_q ? ucnt_q : lcnt_q;
  assign parent    = (idx_q - AW'(1)) >> 1;
  assign c_full    = {idx_q, 1'b1};
  assign bc_next   = {1'b0, bc_q} + CW'(1);
  assign slot_free = !ov_q || m_axis_tready;

  // shared compare unit operands
  always_comb begin
    cmp_a   = v_q;
    cmp_b   = med_q;
    cmp_max = 1'b1;
    case (state_q)
      rmh_pkg::S_PUSH_CMP: begin
        cmp_a   = pv_q;
        cmp_b   = rdata;
        cmp_max = !sel_q;
      end
      rmh_pkg::S_POP_C3: begin
        cmp_a   = rdata;
        cmp_b   = best_q;
        cmp_max = !sel_q;
      end
      rmh_pkg::S_POP_CMP: begin
        cmp_a   = best_q;
        cmp_b   = last_q;
        cmp_max = !sel_q;
      end
      default: begin
        cmp_a   = v_q;
        cmp_b   = med_q;
        cmp_max = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rmh_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = first_hit ? rmh_pkg::S_EMIT : rmh_pkg::S_DECIDE;
        end
      end
      rmh_pkg::S_DECIDE: state_d = full_hit ? rmh_pkg::S_IDLE : rmh_pkg::S_PUSH_RD;
      rmh_pkg::S_PUSH_RD: begin
        if (idx_q != '0) begin
          state_d = rmh_pkg::S_PUSH_CMP;
        end else begin
          state_d = (ph_q == rmh_pkg::PH_INS) ? rmh_pkg::S_POST : rmh_pkg::S_EMIT;
        end
      end
      rmh_pkg::S_PUSH_CMP: begin
        if (above) begin
          state_d = rmh_pkg::S_PUSH_RD;
        end else begin
          state_d = (ph_q == rmh_pkg::PH_INS) ? rmh_pkg::S_POST : rmh_pkg::S_EMIT;
        end
      end
      rmh_pkg::S_POST: begin
        if (!scnt_q[0]) begin
          state_d = rmh_pkg::S_IDLE;
        end else if ((up_q && ucnt_q > lcnt_q) || (!up_q && lcnt_q > ucnt_q)) begin
          state_d = rmh_pkg::S_POP_TOP;
        end else begin
          state_d = rmh_pkg::S_EMIT;
        end
      end
      rmh_pkg::S_POP_TOP: state_d = rmh_pkg::S_POP_LAST;
      rmh_pkg::S_POP_LAST: begin
        state_d = (sel_cnt == CW'(1)) ? rmh_pkg::S_PUSH_RD : rmh_pkg::S_POP_LOAD;
      end
      rmh_pkg::S_POP_LOAD: state_d = rmh_pkg::S_POP_C1;
      rmh_pkg::S_POP_C1: begin
        state_d = (c_full >= n_q) ? rmh_pkg::S_PUSH_RD : rmh_pkg::S_POP_C2;
      end
      rmh_pkg::S_POP_C2: begin
        state_d = (bc_next < n_q) ? rmh_pkg::S_POP_C3 : rmh_pkg::S_POP_CMP;
      end
      rmh_pkg::S_POP_C3:  state_d = rmh_pkg::S_POP_CMP;
      rmh_pkg::S_POP_CMP: state_d = above ? rmh_pkg::S_POP_C1 : rmh_pkg::S_PUSH_RD;
      rmh_pkg::S_EMIT:    state_d = slot_free ? rmh_pkg::S_IDLE : rmh_pkg::S_EMIT;
      default:            state_d = rmh_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    ph_d   = ph_q;
    sel_d  = sel_q;
    up_d   = up_q;
    v_d    = v_q;
    pv_d   = pv_q;
    med_d  = med_q;
    top_d  = top_q;
    last_d = last_q;
    best_d = best_q;
    idx_d  = idx_q;
    bc_d   = bc_q;
    n_d    = n_q;
    lcnt_d = lcnt_q;
    ucnt_d = ucnt_q;
    scnt_d = scnt_q;
    ovf_d  = ovf_q;
    ov_d   = ov_q && !m_axis_tready;
    om_d   = om_q;
    op_d   = op_q;
    oo_d   = oo_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = pv_q;
    mem_raddr = '0;
    case (state_q)
      rmh_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          v_d = s_axis_tdata;
          if (first_hit) begin
            lcnt_d = '0;
            ucnt_d = '0;
            med_d  = s_axis_tdata;
            scnt_d = CW'(1);
            ovf_d  = 1'b0;
          end
        end
      end
      rmh_pkg::S_DECIDE: begin
        if (full_hit) begin
          ovf_d = 1'b1;
        end else begin
          sel_d  = dec_up;
          up_d   = dec_up;
          pv_d   = v_q;
          ph_d   = rmh_pkg::PH_INS;
          idx_d  = tgt_cnt[AW-1:0];
          scnt_d = scnt_q + CW'(1);
          if (dec_up) begin
            ucnt_d = ucnt_q + CW'(1);
          end else begin
            lcnt_d = lcnt_q + CW'(1);
          end
        end
      end
      rmh_pkg::S_PUSH_RD: begin
        if (idx_q != '0) begin
          mem_raddr = parent;
        end else begin
          mem_we = 1'b1;
          if (ph_q == rmh_pkg::PH_MOV) begin
            med_d = top_q;
          end
        end
      end
      rmh_pkg::S_PUSH_CMP: begin
        mem_we = 1'b1;
        if (above) begin
          mem_wdata = rdata;
          idx_d     = parent;
        end else if (ph_q == rmh_pkg::PH_MOV) begin
          med_d = top_q;
        end
      end
      rmh_pkg::S_POST: begin
        sel_d = up_q;
        ph_d  = rmh_pkg::PH_POP;
      end
      rmh_pkg::S_POP_TOP: mem_raddr = '0;
      rmh_pkg::S_POP_LAST: begin
        top_d     = rdata;
        n_d       = sel_cnt - CW'(1);
        mem_raddr = n_d[AW-1:0];
        if (sel_q) begin
          ucnt_d = sel_cnt - CW'(1);
        end else begin
          lcnt_d = sel_cnt - CW'(1);
        end
        if (sel_cnt == CW'(1)) begin
          sel_d = !sel_q;
          pv_d  = med_q;
          ph_d  = rmh_pkg::PH_MOV;
          if (sel_q) begin
            idx_d  = lcnt_q[AW-1:0];
            lcnt_d = lcnt_q + CW'(1);
          end else begin
            idx_d  = ucnt_q[AW-1:0];
            ucnt_d = ucnt_q + CW'(1);
          end
        end
      end
      rmh_pkg::S_POP_LOAD: begin
        last_d = rdata;
        idx_d  = '0;
      end
      rmh_pkg::S_POP_C1: begin
        bc_d      = c_full[AW-1:0];
        mem_raddr = c_full[AW-1:0];
        if (c_full >= n_q) begin
          mem_we    = 1'b1;
          mem_wdata = last_q;
        end
      end
      rmh_pkg::S_POP_C2: begin
        best_d    = rdata;
        mem_raddr = bc_next[AW-1:0];
      end
      rmh_pkg::S_POP_C3: begin
        if (above) begin
          best_d = rdata;
          bc_d   = bc_next[AW-1:0];
        end
      end
      rmh_pkg::S_POP_CMP: begin
        mem_we = 1'b1;
        if (above) begin
          mem_wdata = best_q;
          idx_d     = bc_q;
        end else begin
          mem_wdata = last_q;
        end
      end
      rmh_pkg::S_EMIT: begin
        if (slot_free) begin
          ov_d = 1'b1;
          om_d = med_q;
          op_d = scnt_q;
          oo_d = ovf_q;
        end
      end
      default: ;
    endcase
    // pop finished: move the old median into the other heap
    if ((state_q == rmh_pkg::S_POP_C1 && c_full >= n_q) ||
        (state_q == rmh_pkg::S_POP_CMP && !above)) begin
      sel_d = !sel_q;
      pv_d  = med_q;
      ph_d  = rmh_pkg::PH_MOV;
      if (sel_q) begin
        idx_d  = lcnt_q[AW-1:0];
        lcnt_d = lcnt_q + CW'(1);
      end else begin
        idx_d  = ucnt_q[AW-1:0];
        ucnt_d = ucnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmh_pkg::S_IDLE;
      ph_q    <= rmh_pkg::PH_INS;
      lcnt_q  <= '0;
      ucnt_q  <= '0;
      scnt_q  <= '0;
      med_q   <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      lcnt_q  <= lcnt_d;
      ucnt_q  <= ucnt_d;
      scnt_q  <= scnt_d;
      med_q   <= med_d;
      ovf_q   <= ovf_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q  <= sel_d;
    up_q   <= up_d;
    v_q    <= v_d;
    pv_q   <= pv_d;
    top_q  <= top_d;
    last_q <= last_d;
    best_q <= best_d;
    idx_q  <= idx_d;
    bc_q   <= bc_d;
    n_q    <= n_d;
    om_q   <= om_d;
    op_q   <= op_d;
    oo_q   <= oo_d;
  end

  rmh_heap_ram #(
    .DEPTH (rmh_pkg::HEAP_DEPTH),
    .WIDTH (W)
  ) u_lower (
    .clk_i   (clk_i),
    .we_i    (mem_we && !sel_q),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (lo_rdata)
  );

  rmh_heap_ram #(
    .DEPTH (rmh_pkg::HEAP_DEPTH),
    .WIDTH (W)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (mem_we && sel_q),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (up_rdata)
  );

  assign s_axis_tready = (state_q == rmh_pkg::S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {(rmh_pkg::OUT_DATA_W - W - CW)'(0), op_q, om_q};
  assign m_axis_tuser  = oo_q;

endmodule

// ===== verif/median_checker.sv =====
module median_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          fail_cnt_o,
  output int          pending_o
);

  typedef struct packed {
    logic signed [31:0] median;
    logic [12:0]        position;
    logic               overflowed;
  } median_res_t;

  logic signed [31:0] lo_heap [rmh_pkg::HEAP_DEPTH];
  logic signed [31:0] hi_heap [rmh_pkg::HEAP_DEPTH];
  int                 lo_n, hi_n, seq_n;
  logic signed [31:0] med;
  logic               ovf;
  median_res_t        median_q [$];
  int                 fails;

  assign fail_cnt_o = fails;
  assign pending_o  = median_q.size();

  function automatic logic signed [31:0] heap_rd(bit mx, int i);
    return mx ? lo_heap[i] : hi_heap[i];
  endfunction

  task automatic heap_wr(bit mx, int i, logic signed [31:0] v);
    if (mx) lo_heap[i] = v;
    else hi_heap[i] = v;
  endtask

  // max-heap: larger on top; min-heap: smaller on top
  function automatic bit ranks_above(logic signed [31:0] a, logic signed [31:0] b, bit mx);
    return mx ? (a > b) : (a < b);
  endfunction

  task automatic heap_push(bit mx, logic signed [31:0] v);
    int i, p;
    i = mx ? lo_n : hi_n;
    if (mx) lo_n++;
    else hi_n++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!ranks_above(v, heap_rd(mx, p), mx)) break;
      heap_wr(mx, i, heap_rd(mx, p));
      i = p;
    end
    heap_wr(mx, i, v);
  endtask

  task automatic heap_pop(bit mx, output logic signed [31:0] top);
    int n, i, c;
    logic signed [31:0] last;
    n = mx ? lo_n : hi_n;
    top = heap_rd(mx, 0);
    n--;
    if (mx) lo_n = n;
    else hi_n = n;
    if (n > 0) begin
      last = heap_rd(mx, n);
      i = 0;
      forever begin
        c = 2 * i + 1;
        if (c >= n) break;
        if (c + 1 < n && ranks_above(heap_rd(mx, c + 1), heap_rd(mx, c), mx)) c++;
        if (!ranks_above(heap_rd(mx, c), last, mx)) break;
        heap_wr(mx, i, heap_rd(mx, c));
        i = c;
      end
      heap_wr(mx, i, last);
    end
  endtask

  task automatic update_median(logic signed [31:0] v, logic first);
    bit up;
    logic signed [31:0] t;
    if (first || seq_n == 0) begin
      lo_n = 0;
      hi_n = 0;
      med = v;
      seq_n = 1;
      ovf = 1'b0;
      median_q.push_back('{med, 13'(seq_n), ovf});
    end else begin
      up = v > med;
      if (seq_n >= 8191 || (up ? hi_n : lo_n) >= rmh_pkg::HEAP_DEPTH) begin
        ovf = 1'b1;
      end else begin
        heap_push(!up, v);
        seq_n++;
        if (seq_n % 2 == 1) begin
          if (up && hi_n > lo_n) begin
            heap_pop(1'b0, t);
            heap_push(1'b1, med);
            med = t;
          end else if (!up && lo_n > hi_n) begin
            heap_pop(1'b1, t);
            heap_push(1'b0, med);
            med = t;
          end
          median_q.push_back('{med, 13'(seq_n), ovf});
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    median_res_t exp_r;
    if (!rst_ni) begin
      lo_n  = 0;
      hi_n  = 0;
      seq_n = 0;
      med   = '0;
      ovf   = 1'b0;
      fails = 0;
      median_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) update_median(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        if (median_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result median=%0d position=%0d",
                                    $signed(m_axis_tdata[31:0]), m_axis_tdata[44:32]);
        end else begin
          exp_r = median_q.pop_front();
          if (m_axis_tdata[31:0] !== exp_r.median || m_axis_tdata[44:32] !== exp_r.position ||
              m_axis_tuser !== exp_r.overflowed) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                       exp_r.median, exp_r.position, exp_r.overflowed,
                       $signed(m_axis_tdata[31:0]), m_axis_tdata[44:32], m_axis_tuser);
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          fail_cnt, pending;
  bit          calm = 1'b0;
  bit          finished = 1'b0;
  int          quiet_cycles = 0;
  int          cyc = 0;

  always #5 clk_i = ~clk_i;

  running_median_two_heaps_core dut (.*);

  median_checker u_checker (.*, .fail_cnt_o(fail_cnt), .pending_o(pending));

  task automatic send_sample(logic [31:0] v, logic first);
    if (!calm && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value(int style);
    case (style)
      0: return $urandom_range(0, 15) - 8;
      1: return $urandom();
      2: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                  : 32'h80000000 + $urandom_range(3);
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  // receiver: random stalls, one long hold-off while the sender keeps offering
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc == 1500) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
      m_axis_tready <= calm || $urandom_range(99) >= 10;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000 && !finished) begin
      $display("running_median_two_heaps_core verification failed");
      $finish;
    end
  end

  initial begin
    int len, style;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // no sequence started yet: first flag low still opens one
    send_sample(32'h80000000, 1'b0);
    send_sample(32'h7fffffff, 1'b0);
    send_sample(32'h00000000, 1'b0);
    send_sample(32'hffffffff, 1'b0);
    send_sample(32'h7fffffff, 1'b0);
    send_sample(32'h80000000, 1'b1);
    send_sample(32'h80000000, 1'b0);
    send_sample(32'h80000000, 1'b0);
    for (int i = 0; i < 8; i++) send_sample(32'(i * 3 - 10), 1'b0);
    for (int i = 0; i < 7; i++) send_sample(32'(100 - i * 7), i == 0);
    // random sequences, mostly short
    for (int n = 0; n < 1300; n += len) begin
      calm = n >= 600 && n < 900;
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 30);
      style = $urandom_range(3);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(29) == 0) style = $urandom_range(3);
        send_sample(pick_value(style), k == 0 || $urandom_range(199) == 0);
      end
    end
    calm = 1'b1;
    // one long sequence for deeper heaps
    for (int k = 0; k < 300; k++) send_sample(pick_value(k % 4), k == 0);
    send_sample(32'h12345678, 1'b1);
    send_sample(32'h00000001, 1'b0);
    send_sample(32'hfedcba98, 1'b0);
    s_axis_tvalid <= 1'b0;
    while (pending > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    finished = 1'b1;
    if (fail_cnt == 0 && pending == 0)
      $display("running_median_two_heaps_core verification clean");
    else
      $display("running_median_two_heaps_core verification failed");
    $finish;
  end

endmodule
